>>> rtl/pce_pkg.sv
// Shared types, effect codes and register indexes for the palette color effect unit.
package pce_pkg;

  // Hue coefficients: signed, twelve fraction bits by default.
  localparam int COEF_W  = 14;
  localparam int LEVEL_W = 6;
  localparam int EFFECT_W = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 14;

  // Strength step limits and scale of the contrast and intensity gain.
  localparam int LEVEL_MAX  = 32;
  localparam int UNIT_SCALE = 256;
  localparam int LEVEL_STEP = 8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Effect codes; the last one passes the color through unchanged.
  typedef enum logic [EFFECT_W-1:0] {
    EFFECT_CONTRAST  = 2'd0,
    EFFECT_INTENSITY = 2'd1,
    EFFECT_HUE       = 2'd2,
    EFFECT_BYPASS    = 2'd3
  } effect_t;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_EFFECT       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HUE_DIAG_RED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HUE_DIAG_GB  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HUE_MINUS    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HUE_PLUS     = 3'd5;

endpackage

>>> rtl/pce_scale.sv
// One channel of the contrast and intensity scaler with clamping.
module pce_scale import pce_pkg::*; #(
  parameter int CHANNEL_BITS = 5
) (
  input  logic [CHANNEL_BITS-1:0] x_i,
  input  level_t                  level_i,
  input  logic                    offset_en_i,
  output logic [CHANNEL_BITS-1:0] y_o
);

  localparam int GAIN_W = LEVEL_W + 4;
  localparam int PROD_W = GAIN_W + CHANNEL_BITS;
  localparam int TW     = PROD_W + 2;
  localparam int SHIFT  = 8;
  localparam int QW     = TW - SHIFT;
  localparam logic [QW-1:0] CH_MAX = QW'((1 << CHANNEL_BITS) - 1);

  logic [GAIN_W-1:0]    gain;
  logic [PROD_W-1:0]    prod;
  logic [TW-1:0]        offset;
  logic signed [TW-1:0] t;
  logic [QW-1:0]        q;

  // Gain of 256 + 8c applied to the channel.
  assign gain = GAIN_W'(UNIT_SCALE) + GAIN_W'({level_i, 3'b000});
  assign prod = gain * x_i;

  // Contrast pulls the midpoint back by 4c times the channel range.
  assign offset = offset_en_i ? (TW'(level_i) << (CHANNEL_BITS + 2)) : '0;
  assign t      = $signed({2'b00, prod}) - $signed(offset);
  assign q      = t[TW-1:SHIFT];

  // Negative or zero clamps to black, overflow clamps to full scale.
  always_comb begin
    if (t[TW-1] || (t == '0)) begin
      y_o = '0;
    end else if (q > CH_MAX) begin
      y_o = CH_MAX[CHANNEL_BITS-1:0];
    end else begin
      y_o = q[CHANNEL_BITS-1:0];
    end
  end

endmodule

>>> rtl/pce_hue_row.sv
// One row of the hue rotation matrix: three products, a sum, a floor shift and a clamp.
module pce_hue_row import pce_pkg::*; #(
  parameter int CHANNEL_BITS = 5,
  parameter int FRAC_BITS    = 12
) (
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  input  coef_t                   k_red_i,
  input  coef_t                   k_green_i,
  input  coef_t                   k_blue_i,
  output logic [CHANNEL_BITS-1:0] y_o
);

  localparam int SW = COEF_W + CHANNEL_BITS + 3;
  localparam int QW = SW - FRAC_BITS;
  localparam logic [QW-1:0] CH_MAX = QW'((1 << CHANNEL_BITS) - 1);

  logic signed [SW-1:0] p_red;
  logic signed [SW-1:0] p_green;
  logic signed [SW-1:0] p_blue;
  logic signed [SW-1:0] sum;
  logic [QW-1:0]        q;

  // Signed coefficient times unsigned channel.
  assign p_red   = SW'(k_red_i)   * SW'($signed({1'b0, red_i}));
  assign p_green = SW'(k_green_i) * SW'($signed({1'b0, green_i}));
  assign p_blue  = SW'(k_blue_i)  * SW'($signed({1'b0, blue_i}));
  assign sum     = p_red + p_green + p_blue;
  assign q       = sum[SW-1:FRAC_BITS];

  // Floor by the fraction bits and clamp to the channel range.
  always_comb begin
    if (sum[SW-1] || (sum == '0)) begin
      y_o = '0;
    end else if (q > CH_MAX) begin
      y_o = CH_MAX[CHANNEL_BITS-1:0];
    end else begin
      y_o = q[CHANNEL_BITS-1:0];
    end
  end

endmodule

>>> rtl/palette_color_effect_unit.sv
// Top level of the palette color effect unit: registers, pipeline and effect select.
//
// Usage: palette colors enter on the in_ stream, one word per color with red,
// green and blue packed in in_tdata and the run end in in_tlast. Each color
// leaves on the out_ stream as one word in the same layout, with out_tlast
// copied from the input. The effect (contrast, intensity, hue shift or pass
// through) and its strength or matrix coefficients come from the cfg_ write
// port; the user must write them only while no color is in flight, since the
// block does not enforce it. A color accepted into the input register passes
// through the arithmetic into the result register, which offers it on out_.
// Throughput: one color per cycle while out_tready is high, set by a two-register
// pipeline (input register, then result register) with all arithmetic between them.
// Reset (rst_n low, synchronous) empties both pipeline registers and loads the
// effect registers with contrast, level 0 and the identity hue matrix.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more color; in_tready drops once both are full.
module palette_color_effect_unit import pce_pkg::*; #(
  parameter int CHANNEL_BITS = 5,
  parameter int FRAC_BITS    = 12,
  localparam int DATA_W      = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,  // red_in, green_in, blue_in, zero fill
  input  logic                  in_tlast,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata, // red_out, green_out, blue_out, zero fill
  output logic                  out_tlast,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CB = CHANNEL_BITS;

  effect_t effect_r;
  level_t  level_r;
  coef_t   hue_diag_red_r;
  coef_t   hue_diag_gb_r;
  coef_t   hue_minus_r;
  coef_t   hue_plus_r;

  logic          s1_valid_r;
  logic [CB-1:0] s1_red_r;
  logic [CB-1:0] s1_green_r;
  logic [CB-1:0] s1_blue_r;
  logic          s1_last_r;

  logic          out_valid_r;
  logic [CB-1:0] out_red_r;
  logic [CB-1:0] out_green_r;
  logic [CB-1:0] out_blue_r;
  logic          out_last_r;

  logic          advance;
  level_t        level_sat;
  logic          offset_en;
  logic [CB-1:0] sc_red;
  logic [CB-1:0] sc_green;
  logic [CB-1:0] sc_blue;
  logic [CB-1:0] hue_red;
  logic [CB-1:0] hue_green;
  logic [CB-1:0] hue_blue;
  logic [CB-1:0] red_nxt;
  logic [CB-1:0] green_nxt;
  logic [CB-1:0] blue_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r       <= EFFECT_CONTRAST;
      level_r        <= '0;
      hue_diag_red_r <= coef_t'(4096);
      hue_diag_gb_r  <= coef_t'(4096);
      hue_minus_r    <= '0;
      hue_plus_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EFFECT:       effect_r       <= effect_t'(cfg_wdata[EFFECT_W-1:0]);
        REG_LEVEL:        level_r        <= cfg_wdata[LEVEL_W-1:0];
        REG_HUE_DIAG_RED: hue_diag_red_r <= coef_t'(cfg_wdata);
        REG_HUE_DIAG_GB:  hue_diag_gb_r  <= coef_t'(cfg_wdata);
        REG_HUE_MINUS:    hue_minus_r    <= coef_t'(cfg_wdata);
        REG_HUE_PLUS:     hue_plus_r     <= coef_t'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: the result register moves when empty or taken.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_red_r   <= in_tdata[CB-1:0];
      s1_green_r <= in_tdata[2*CB-1:CB];
      s1_blue_r  <= in_tdata[3*CB-1:2*CB];
      s1_last_r  <= in_tlast;
    end
  end

  // Strength saturates at the top step.
  assign level_sat = (level_r > level_t'(LEVEL_MAX)) ? level_t'(LEVEL_MAX) : level_r;
  assign offset_en = (effect_r == EFFECT_CONTRAST);

  // Contrast and intensity scalers, one per channel.
  pce_scale #(.CHANNEL_BITS(CB)) u_scale_red (
    .x_i(s1_red_r), .level_i(level_sat), .offset_en_i(offset_en), .y_o(sc_red)
  );
  pce_scale #(.CHANNEL_BITS(CB)) u_scale_green (
    .x_i(s1_green_r), .level_i(level_sat), .offset_en_i(offset_en), .y_o(sc_green)
  );
  pce_scale #(.CHANNEL_BITS(CB)) u_scale_blue (
    .x_i(s1_blue_r), .level_i(level_sat), .offset_en_i(offset_en), .y_o(sc_blue)
  );

  // Hue matrix rows; the matrix is circulant in the off-diagonal terms.
  pce_hue_row #(.CHANNEL_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_hue_red (
    .red_i(s1_red_r), .green_i(s1_green_r), .blue_i(s1_blue_r),
    .k_red_i(hue_diag_red_r), .k_green_i(hue_minus_r), .k_blue_i(hue_plus_r),
    .y_o(hue_red)
  );
  pce_hue_row #(.CHANNEL_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_hue_green (
    .red_i(s1_red_r), .green_i(s1_green_r), .blue_i(s1_blue_r),
    .k_red_i(hue_plus_r), .k_green_i(hue_diag_gb_r), .k_blue_i(hue_minus_r),
    .y_o(hue_green)
  );
  pce_hue_row #(.CHANNEL_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_hue_blue (
    .red_i(s1_red_r), .green_i(s1_green_r), .blue_i(s1_blue_r),
    .k_red_i(hue_minus_r), .k_green_i(hue_plus_r), .k_blue_i(hue_diag_gb_r),
    .y_o(hue_blue)
  );

  // Effect select.
  always_comb begin
    unique case (effect_r)
      EFFECT_CONTRAST, EFFECT_INTENSITY: begin
        red_nxt   = sc_red;
        green_nxt = sc_green;
        blue_nxt  = sc_blue;
      end
      EFFECT_HUE: begin
        red_nxt   = hue_red;
        green_nxt = hue_green;
        blue_nxt  = hue_blue;
      end
      EFFECT_BYPASS: begin
        red_nxt   = s1_red_r;
        green_nxt = s1_green_r;
        blue_nxt  = s1_blue_r;
      end
      default: begin
        red_nxt   = s1_red_r;
        green_nxt = s1_green_r;
        blue_nxt  = s1_blue_r;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_blue_r, out_green_r, out_red_r});
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // A word in the input register always reaches the result register when it moves.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("input register word lost on advance");

  // Back-pressure only when both pipeline registers are full and the receiver stalls.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low without a full stalled pipeline");

  // A stalled input register keeps its word.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_red_r) && $stable(s1_last_r)))
    else $error("input register changed while stalled");

  // An effect write lands in the effect register.
  a_cfg_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_addr == REG_EFFECT)) |=> (effect_r == $past(cfg_wdata[EFFECT_W-1:0])))
    else $error("effect register write not taken");
`endif

endmodule
